// ===== rtl/gara_pkg.sv =====
// Shared types and constants for the glyph atlas row allocator.
package gara_pkg;

  localparam int unsigned CHAR_W    = 21;
  localparam int unsigned GWIDTH_W  = 8;
  localparam int unsigned ATLAS_W   = 13;
  localparam int unsigned RHEIGHT_W = 8;
  localparam int unsigned RCOUNT_W  = 7;
  localparam int unsigned INDEX_W   = 8;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned NEED_W    = GWIDTH_W + 1;

  localparam int unsigned MAX_ROWS_DEF   = 64;
  localparam int unsigned MAX_GLYPHS_DEF = 256;

  localparam logic [CHAR_W-1:0]    SPACE_CODE = CHAR_W'(32);
  localparam logic [NEED_W-1:0]    GLYPH_PAD  = NEED_W'(1);

  localparam logic [ATLAS_W-1:0]   ATLAS_WIDTH_RST = ATLAS_W'(1024);
  localparam logic [RHEIGHT_W-1:0] ROW_HEIGHT_RST  = RHEIGHT_W'(16);
  localparam logic [RCOUNT_W-1:0]  ROW_COUNT_RST   = RCOUNT_W'(64);

  localparam int unsigned PADDR_W = 4;

  typedef enum logic [1:0] {
    REG_ATLAS_WIDTH = 2'd0,
    REG_ROW_HEIGHT  = 2'd1,
    REG_ROW_COUNT   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_PRESENT = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TAG,
    S_ROW,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [CHAR_W-1:0]   character;
    logic [GWIDTH_W-1:0] glyph_width;
    logic [GWIDTH_W-1:0] glyph_advance;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [INDEX_W-1:0] glyph_index;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
  } rsp_t;

endpackage

// ===== rtl/glyph_atlas_row_allocator.sv =====
// Glyph atlas row allocator: tag scan then first-fit row scan, one request at a time.
// Scan: one tag per cycle over the char store, then one row per cycle over the fill store.
// A request is served to its end before the next; the single read port of each store sets the pace.
// A new request is taken while the previous result still waits in the output register.
// Reset: control, config registers and row valid bits clear at once; no clearing pass.
module glyph_atlas_row_allocator #(
  parameter int unsigned MAX_ROWS   = gara_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_GLYPHS = gara_pkg::MAX_GLYPHS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  gara_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output gara_pkg::rsp_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gara_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import gara_pkg::*;

  localparam int unsigned GCW = $clog2(MAX_GLYPHS + 1);
  localparam int unsigned GIW = $clog2(MAX_GLYPHS);
  localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
  localparam int unsigned RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // config registers
  logic [ATLAS_W-1:0]   atlas_width_q;
  logic [RHEIGHT_W-1:0] row_height_q;
  logic [RCOUNT_W-1:0]  row_count_q;
  reg_idx_e             reg_idx;
  logic                 cfg_we;

  state_e               state_q, state_d;
  logic [CHAR_W-1:0]    code_q, code_d;
  logic [NEED_W-1:0]    need_q, need_d;
  logic [GCW-1:0]       gcnt_q, gcnt_d;
  logic [GCW-1:0]       tptr_q, tptr_d;
  logic [RCW-1:0]       rptr_q, rptr_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [GIW-1:0]       cmp_tidx_q, cmp_tidx_d;
  logic [RIW-1:0]       cmp_ridx_q, cmp_ridx_d;
  rsp_t                 res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 out_data_q, out_data_d;

  // stores
  logic [CHAR_W-1:0]    tag_mem [MAX_GLYPHS];
  logic [CHAR_W-1:0]    tag_rdata_q;
  logic [ATLAS_W-1:0]   row_mem [MAX_ROWS];
  logic [ATLAS_W-1:0]   row_rdata_q;
  logic                 row_rv_q;
  logic [MAX_ROWS-1:0]  row_vld_q;

  logic                 accept;
  logic                 out_free;
  logic                 tag_hit, tag_more, tbl_full;
  logic                 tag_re;
  logic                 row_hit, row_more, row_re, row_we;
  logic [RCW-1:0]       rows_lim;
  logic [ATLAS_W-1:0]   fill_cur;
  logic [ATLAS_W:0]     fill_sum;
  logic [RIW+7:0]       ypos;

  // ---------------- config port ----------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_width_q <= ATLAS_WIDTH_RST;
      row_height_q  <= ROW_HEIGHT_RST;
      row_count_q   <= ROW_COUNT_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_ATLAS_WIDTH: atlas_width_q <= pwdata[ATLAS_W-1:0];
        REG_ROW_HEIGHT:  row_height_q  <= pwdata[RHEIGHT_W-1:0];
        REG_ROW_COUNT:   row_count_q   <= pwdata[RCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ATLAS_WIDTH: prdata = 32'(atlas_width_q);
      REG_ROW_HEIGHT:  prdata = 32'(row_height_q);
      REG_ROW_COUNT:   prdata = 32'(row_count_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------- scan decisions ----------------
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign tag_hit  = cmp_vld_q && (tag_rdata_q == code_q);
  assign tag_more = (tptr_q != gcnt_q);
  assign tbl_full = (gcnt_q == GCW'(MAX_GLYPHS));
  assign tag_re   = (state_q == S_TAG) && !tag_hit && tag_more;

  always_comb begin
    if (32'(row_count_q) > MAX_ROWS) rows_lim = RCW'(MAX_ROWS);
    else                             rows_lim = RCW'(row_count_q);
  end

  // unwritten rows read as empty
  assign fill_cur = row_rv_q ? row_rdata_q : '0;
  assign fill_sum = {1'b0, fill_cur} + (ATLAS_W+1)'(need_q);
  assign row_hit  = cmp_vld_q && (fill_sum <= {1'b0, atlas_width_q});
  assign row_more = (rptr_q != rows_lim);
  assign row_re   = (state_q == S_ROW) && !row_hit && row_more;
  assign row_we   = (state_q == S_ROW) && row_hit;

  assign ypos = (RIW+8)'(cmp_ridx_q) * (RIW+8)'(row_height_q);

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_TAG;
      S_TAG: begin
        if (tag_hit)       state_d = S_OUT;
        else if (tag_more) state_d = S_TAG;
        else if (tbl_full) state_d = S_OUT;
        else               state_d = S_ROW;
      end
      S_ROW: begin
        if (row_hit)       state_d = S_OUT;
        else if (row_more) state_d = S_ROW;
        else               state_d = S_OUT;
      end
      S_OUT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- datapath control ----------------
  always_comb begin
    code_d      = code_q;
    need_d      = need_q;
    gcnt_d      = gcnt_q;
    tptr_d      = tptr_q;
    rptr_d      = rptr_q;
    cmp_vld_d   = 1'b0;
    cmp_tidx_d  = cmp_tidx_q;
    cmp_ridx_d  = cmp_ridx_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          code_d = in_data_i.character;
          if (in_data_i.character == SPACE_CODE)
            need_d = NEED_W'(in_data_i.glyph_advance) + GLYPH_PAD;
          else
            need_d = NEED_W'(in_data_i.glyph_width) + GLYPH_PAD;
          tptr_d = '0;
        end
      end
      S_TAG: begin
        if (tag_hit) begin
          res_d = '{status: ST_PRESENT, glyph_index: INDEX_W'(cmp_tidx_q),
                    pos_x: '0, pos_y: '0};
        end else if (tag_more) begin
          cmp_vld_d  = 1'b1;
          cmp_tidx_d = tptr_q[GIW-1:0];
          tptr_d     = tptr_q + GCW'(1);
        end else if (tbl_full) begin
          res_d = '{status: ST_FULL, glyph_index: '0, pos_x: '0, pos_y: '0};
        end else begin
          rptr_d = '0;
        end
      end
      S_ROW: begin
        if (row_hit) begin
          gcnt_d = gcnt_q + GCW'(1);
          res_d  = '{status: ST_PLACED, glyph_index: INDEX_W'(gcnt_q),
                     pos_x: POS_W'(fill_cur), pos_y: POS_W'(ypos)};
        end else if (row_more) begin
          cmp_vld_d  = 1'b1;
          cmp_ridx_d = rptr_q[RIW-1:0];
          rptr_d     = rptr_q + RCW'(1);
        end else begin
          res_d = '{status: ST_NOSPACE, glyph_index: '0, pos_x: '0, pos_y: '0};
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gcnt_q      <= '0;
      tptr_q      <= '0;
      rptr_q      <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      row_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      gcnt_q      <= gcnt_d;
      tptr_q      <= tptr_d;
      rptr_q      <= rptr_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
      if (row_we) row_vld_q[cmp_ridx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    need_q     <= need_d;
    cmp_tidx_q <= cmp_tidx_d;
    cmp_ridx_q <= cmp_ridx_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  // char store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (row_we) tag_mem[gcnt_q[GIW-1:0]] <= code_q;
    if (tag_re) tag_rdata_q <= tag_mem[tptr_q[GIW-1:0]];
  end

  // row fill store
  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[cmp_ridx_q] <= fill_sum[ATLAS_W-1:0];
    if (row_re) begin
      row_rdata_q <= row_mem[rptr_q[RIW-1:0]];
      row_rv_q    <= row_vld_q[rptr_q[RIW-1:0]];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== test/testbench.sv =====
// Testbench for the glyph atlas row allocator against a shelf-packing predictor.
`timescale 1ns / 100ps

module testbench;
  import gara_pkg::*;

  localparam int unsigned ROWS        = MAX_ROWS_DEF;
  localparam int unsigned GLYPHS      = MAX_GLYPHS_DEF;
  localparam int unsigned LONG_HOLD   = 800;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned DRAIN_WAIT  = 400;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  req_t in_data = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         apb_rdata;
  logic                apb_ready;

  glyph_atlas_row_allocator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (apb_rdata),
    .pready      (apb_ready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow of the allocator's layout registers and packing state
  logic [ATLAS_W-1:0]   atlas_cfg  = ATLAS_WIDTH_RST;
  logic [RHEIGHT_W-1:0] height_cfg = ROW_HEIGHT_RST;
  logic [RCOUNT_W-1:0]  rows_cfg   = ROW_COUNT_RST;
  logic [ATLAS_W-1:0]   row_fill [ROWS];
  logic [CHAR_W-1:0]    char_table [GLYPHS];
  int unsigned          glyph_count = 0;

  req_t req_q [$];
  rsp_t answer_q [$];
  int unsigned bad_beats = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  logic        rsp_hold_go = 1'b0;
  int unsigned rsp_hold_cnt = 0;

  initial begin
    for (int i = 0; i < ROWS; i++) row_fill[i] = '0;
  end

  function automatic rsp_t place_glyph(req_t r);
    rsp_t        a;
    int unsigned need;
    int unsigned rows;
    int unsigned fill;
    a = '0;
    for (int i = 0; i < glyph_count && i < GLYPHS; i++) begin
      if (char_table[i] == r.character) begin
        a.status = ST_PRESENT;
        a.glyph_index = INDEX_W'(i);
        return a;
      end
    end
    if (glyph_count >= GLYPHS) begin
      a.status = ST_FULL;
      return a;
    end
    need = ((r.character == SPACE_CODE) ? r.glyph_advance : r.glyph_width) + GLYPH_PAD;
    rows = (rows_cfg > ROWS) ? ROWS : rows_cfg;
    for (int i = 0; i < rows; i++) begin
      fill = row_fill[i];
      if (fill <= atlas_cfg && atlas_cfg - fill >= need) begin
        row_fill[i] = ATLAS_W'(fill + need);
        char_table[glyph_count] = r.character;
        a.status = ST_PLACED;
        a.glyph_index = INDEX_W'(glyph_count);
        a.pos_x = POS_W'(fill);
        a.pos_y = POS_W'(i * height_cfg);
        glyph_count++;
        return a;
      end
    end
    a.status = ST_NOSPACE;
    return a;
  endfunction

  // Request driver: valid holds until the beat is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) answer_q.push_back(place_glyph(in_data));
      if (!in_valid || !in_stall) begin
        if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= req_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and stall generator
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          bad_beats++;
          if (bad_beats <= MAX_REPORTS)
            $display("unexpected result beat: status %0d index %0d x %0d y %0d",
                     out_data.status, out_data.glyph_index, out_data.pos_x, out_data.pos_y);
        end else begin
          exp_rsp = answer_q.pop_front();
          if (out_data.status !== exp_rsp.status ||
              out_data.glyph_index !== exp_rsp.glyph_index ||
              out_data.pos_x !== exp_rsp.pos_x ||
              out_data.pos_y !== exp_rsp.pos_y) begin
            bad_beats++;
            if (bad_beats <= MAX_REPORTS)
              $display("mismatch: exp status %0d index %0d x %0d y %0d, got %0d %0d %0d %0d",
                       exp_rsp.status, exp_rsp.glyph_index, exp_rsp.pos_x, exp_rsp.pos_y,
                       out_data.status, out_data.glyph_index, out_data.pos_x,
                       out_data.pos_y);
          end
        end
      end
      if (rsp_hold_go && rsp_hold_cnt < LONG_HOLD) begin
        out_stall <= 1'b1;
        rsp_hold_cnt++;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic apb_write(reg_idx_e r, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_ATLAS_WIDTH: atlas_cfg = v[ATLAS_W-1:0];
      REG_ROW_HEIGHT:  height_cfg = v[RHEIGHT_W-1:0];
      REG_ROW_COUNT:   rows_cfg = v[RCOUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (req_q.size() > 0 || in_valid || answer_q.size() > 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic queue_req(logic [CHAR_W-1:0] c, logic [GWIDTH_W-1:0] w,
                           logic [GWIDTH_W-1:0] adv);
    req_t r;
    r.character = c;
    r.glyph_width = w;
    r.glyph_advance = adv;
    req_q.push_back(r);
  endtask

  // Mix of repeats of known codes, spaces and fresh codes
  task automatic queue_random(int unsigned n, int unsigned known_pct, int unsigned wide_pct);
    req_t        r;
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      r.glyph_advance = GWIDTH_W'($urandom_range(0, 255));
      r.glyph_width = ($urandom_range(0, 99) < wide_pct) ? GWIDTH_W'($urandom_range(0, 255))
                                                          : GWIDTH_W'($urandom_range(0, 40));
      if (pick < known_pct && glyph_count > 0)
        r.character = char_table[$urandom_range(0, glyph_count - 1)];
      else if (pick < known_pct + 4)
        r.character = SPACE_CODE;
      else
        r.character = CHAR_W'($urandom());
      req_q.push_back(r);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: narrow two-row atlas, exact fits, repeats and spaces
    apb_write(REG_ATLAS_WIDTH, 40);
    apb_write(REG_ROW_HEIGHT, 255);
    apb_write(REG_ROW_COUNT, 2);
    queue_req('0, 8'd0, 8'd0);
    queue_req('1, 8'd255, 8'd255);
    queue_req(SPACE_CODE, 8'd200, 8'd5);
    queue_req(SPACE_CODE, 8'd0, 8'd0);
    queue_req('0, 8'd9, 8'd9);
    queue_req(CHAR_W'(33), 8'd38, 8'd0);
    queue_req(CHAR_W'(34), 8'd32, 8'd0);
    queue_req(CHAR_W'(35), 8'd0, 8'd0);
    queue_req(CHAR_W'(36), 8'd0, 8'd7);
    wait_drained();

    // No rows in use: every new code is out of space
    apb_write(REG_ROW_COUNT, 0);
    queue_req(CHAR_W'(37), 8'd10, 8'd0);
    queue_req(SPACE_CODE, 8'd1, 8'd1);
    wait_drained();

    // Row count beyond the row store is clamped
    apb_write(REG_ROW_COUNT, 127);
    queue_req(CHAR_W'(37), 8'd10, 8'd0);
    queue_req(CHAR_W'(38), 8'd255, 8'd0);
    wait_drained();

    // Width lowered below the fill of used rows
    apb_write(REG_ATLAS_WIDTH, 5);
    queue_req(CHAR_W'(39), 8'd3, 8'd0);
    queue_req(CHAR_W'(40), 8'd4, 8'd0);
    wait_drained();
    apb_write(REG_ATLAS_WIDTH, 1);
    queue_req(CHAR_W'(41), 8'd0, 8'd0);
    queue_req(CHAR_W'(42), 8'd0, 8'd0);
    wait_drained();

    apb_write(REG_ATLAS_WIDTH, 8191);
    apb_write(REG_ROW_HEIGHT, 1);
    queue_req(CHAR_W'(43), 8'd255, 8'd0);
    queue_req(CHAR_W'(44), 8'd255, 8'd0);
    wait_drained();

    // Random phase 1: default layout, no idling; sender pauses midway for a full drain
    apb_write(REG_ATLAS_WIDTH, 1024);
    apb_write(REG_ROW_HEIGHT, 16);
    apb_write(REG_ROW_COUNT, 64);
    queue_random(50, 35, 10);
    wait_drained();
    queue_random(50, 35, 10);
    wait_drained();

    // Random phase 2: 4096-wide atlas, tallest rows, idle sender
    apb_write(REG_ATLAS_WIDTH, 4096);
    apb_write(REG_ROW_HEIGHT, 255);
    send_idle_pct = 75;
    queue_random(100, 35, 15);
    wait_drained();

    // Random phase 3: cramped layout, stalling receiver with one long hold-off
    send_idle_pct = 0;
    rsp_stall_pct = 75;
    apb_write(REG_ATLAS_WIDTH, 300);
    apb_write(REG_ROW_HEIGHT, 1);
    apb_write(REG_ROW_COUNT, 3);
    rsp_hold_go = 1'b1;
    queue_random(100, 35, 20);
    wait_drained();

    // Random phase 4: both sides idle, mostly fresh codes to run into a full table
    send_idle_pct = 28;
    rsp_stall_pct = 28;
    apb_write(REG_ATLAS_WIDTH, 2048);
    apb_write(REG_ROW_HEIGHT, 200);
    apb_write(REG_ROW_COUNT, 127);
    queue_random(150, 15, 10);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (bad_beats == 0 && answer_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
